FILE: rtl/core/bfa_pkg.sv
package bfa_pkg;

    localparam int MAX_BINS = 21;

    // magnitude cutoffs, coarsest first
    localparam logic [63:0] CUTOFF [MAX_BINS] = '{
        $realtobits(2.0),    $realtobits(3e-16),  $realtobits(3e-32),
        $realtobits(3e-48),  $realtobits(3e-64),  $realtobits(3e-80),
        $realtobits(3e-96),  $realtobits(3e-112), $realtobits(3e-128),
        $realtobits(3e-144), $realtobits(3e-160), $realtobits(3e-176),
        $realtobits(3e-192), $realtobits(3e-208), $realtobits(3e-224),
        $realtobits(3e-240), $realtobits(3e-256), $realtobits(3e-272),
        $realtobits(3e-288), $realtobits(3e-304), $realtobits(3e-308)
    };

    localparam logic [1:0] OP_ACC   = 2'd0;
    localparam logic [1:0] OP_READ  = 2'd1;
    localparam logic [1:0] OP_CLEAR = 2'd2;
    localparam logic [1:0] OP_SPARE = 2'd3;

    // register index (word address bit) of the mode register
    localparam logic REG_CAREFUL = 1'b0;

    localparam logic [63:0] DEFAULT_NAN = 64'hFFF8_0000_0000_0000;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_ACC_LOAD,
        ST_ACC_WAIT,
        ST_SW_LOAD,
        ST_SW_CMP,
        ST_SW_ADD,
        ST_SW_WAIT,
        ST_RD_ADD,
        ST_RD_WAIT,
        ST_OUT
    } t_state;

    // x < c for a positive finite constant c
    function automatic logic f_lt_pos(input logic [63:0] x, input logic [63:0] c);
        logic is_nan;
        is_nan = (x[62:52] == 11'h7FF) && (x[51:0] != 52'd0);
        return !is_nan && (x[63] || (x[62:0] < c[62:0]));
    endfunction

    // x > c for a positive finite constant c
    function automatic logic f_gt_pos(input logic [63:0] x, input logic [63:0] c);
        logic is_nan;
        is_nan = (x[62:52] == 11'h7FF) && (x[51:0] != 52'd0);
        return !is_nan && !x[63] && (x[62:0] > c[62:0]);
    endfunction

endpackage

FILE: rtl/core/binned_float_accumulator_unit.sv
// accumulate: add the term into its destination bin, then sweep the bins in use from
// finest to coarsest, carrying any bin above its cutoff into the next coarser bin
// (each double add goes through the shared adder); a dropped term skips the first add
// read: sum the bins in use, finest first, then output; clear and unused opcodes: no add
// one item at a time, taken only while idle; one five-stage double adder for all steps
// reset (synchronous, active low) zeroes all bins through their valid bits and sets
// careful mode; the result register may keep one beat while the next item is taken
module binned_float_accumulator_unit
    import bfa_pkg::*;
#(
    parameter int NUM_BINS = 21
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // stream in
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    input  logic [63:0] i_s_axis_tdata,   // [63:0] term_bits
    input  logic [1:0]  i_s_axis_tuser,   // [1:0] opcode
    // stream out
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    output logic [63:0] o_m_axis_tdata,   // [63:0] sum_bits
    // register port
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    localparam int IW = (NUM_BINS > 1) ? $clog2(NUM_BINS) : 1;

    t_state r_state, n_state;

    logic [IW-1:0] r_idx, n_idx;
    logic [63:0]   r_term, n_term;
    logic [63:0]   r_cur, n_cur;        // running sweep value of the bin at r_idx
    logic [63:0]   r_acc, n_acc;        // read total
    logic [63:0]   r_opa, n_opa, r_opb, n_opb;
    logic          r_start, n_start;
    logic          r_careful;
    logic          r_out_vld, n_out_vld;
    logic [63:0]   r_out, n_out;

    // bin store: one read and one write address per cycle
    logic [63:0]         r_bin [NUM_BINS];
    logic [NUM_BINS-1:0] r_bin_vld;
    logic                w_we, w_clr_one, w_clr_all;
    logic [63:0]         w_wdata;
    logic [63:0]         rd_bin;

    logic        add_busy, add_done;
    logic [63:0] add_res;

    logic [IW-1:0] top_idx;
    logic [IW-1:0] tgt;
    logic          tgt_hit;
    logic          s_beat, m_beat, cfg_wr;
    logic [63:0]   cut_cur;

    assign top_idx = r_careful ? IW'(NUM_BINS - 1) : IW'(1);
    assign rd_bin  = r_bin_vld[r_idx] ? r_bin[r_idx] : 64'd0;
    assign cut_cur = CUTOFF[r_idx];

    // destination bin: finest in use whose cutoff is above the term
    always_comb begin
        tgt     = '0;
        tgt_hit = 1'b0;
        for (int k = 0; k < NUM_BINS; k++) begin
            if (IW'(k) <= top_idx && f_lt_pos(i_s_axis_tdata, CUTOFF[k])) begin
                tgt     = IW'(k);
                tgt_hit = 1'b1;
            end
        end
    end

    bfa_fp_add u_add (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (r_start),
        .i_a     (r_opa),
        .i_b     (r_opb),
        .o_busy  (add_busy),
        .o_done  (add_done),
        .o_res   (add_res)
    );

    assign o_s_axis_tready = (r_state == ST_IDLE);
    assign s_beat          = i_s_axis_tvalid && o_s_axis_tready;
    assign m_beat          = r_out_vld && i_m_axis_tready;

    // sequencer
    always_comb begin
        n_state   = r_state;
        n_idx     = r_idx;
        n_term    = r_term;
        n_cur     = r_cur;
        n_acc     = r_acc;
        n_opa     = r_opa;
        n_opb     = r_opb;
        n_start   = 1'b0;
        n_out_vld = m_beat ? 1'b0 : r_out_vld;
        n_out     = r_out;
        w_we      = 1'b0;
        w_clr_one = 1'b0;
        w_clr_all = 1'b0;
        w_wdata   = add_res;
        unique case (r_state)
            ST_IDLE: begin
                if (s_beat) begin
                    unique case (i_s_axis_tuser)
                        OP_ACC: begin
                            n_term = i_s_axis_tdata;
                            if (tgt_hit) begin
                                n_idx   = tgt;
                                n_state = ST_ACC_LOAD;
                            end else begin
                                // large or NaN term is dropped, sweep still runs
                                n_idx   = top_idx;
                                n_state = ST_SW_LOAD;
                            end
                        end
                        OP_READ: begin
                            n_acc   = 64'd0;
                            n_idx   = top_idx;
                            n_state = ST_RD_ADD;
                        end
                        OP_CLEAR: begin
                            w_clr_all = 1'b1;
                        end
                        default: begin
                        end
                    endcase
                end
            end
            ST_ACC_LOAD: begin
                n_opa   = rd_bin;
                n_opb   = r_term;
                n_start = 1'b1;
                n_state = ST_ACC_WAIT;
            end
            ST_ACC_WAIT: begin
                if (add_done) begin
                    w_we    = 1'b1;
                    n_idx   = top_idx;
                    n_state = ST_SW_LOAD;
                end
            end
            ST_SW_LOAD: begin
                n_cur   = rd_bin;
                n_state = ST_SW_CMP;
            end
            ST_SW_CMP: begin
                n_idx = r_idx - IW'(1);
                if (f_gt_pos(r_cur, cut_cur)) begin
                    // carry into the next coarser bin
                    w_clr_one = 1'b1;
                    n_state   = ST_SW_ADD;
                end else if (r_idx == IW'(1)) begin
                    n_state = ST_IDLE;
                end else begin
                    n_state = ST_SW_LOAD;
                end
            end
            ST_SW_ADD: begin
                n_opa   = rd_bin;
                n_opb   = r_cur;
                n_start = 1'b1;
                n_state = ST_SW_WAIT;
            end
            ST_SW_WAIT: begin
                if (add_done) begin
                    w_we  = 1'b1;
                    n_cur = add_res;
                    n_state = (r_idx == '0) ? ST_IDLE : ST_SW_CMP;
                end
            end
            ST_RD_ADD: begin
                n_opa   = r_acc;
                n_opb   = rd_bin;
                n_start = 1'b1;
                n_state = ST_RD_WAIT;
            end
            ST_RD_WAIT: begin
                if (add_done) begin
                    n_acc = add_res;
                    if (r_idx == '0) begin
                        n_state = ST_OUT;
                    end else begin
                        n_idx   = r_idx - IW'(1);
                        n_state = ST_RD_ADD;
                    end
                end
            end
            ST_OUT: begin
                if (!r_out_vld || m_beat) begin
                    n_out_vld = 1'b1;
                    n_out     = r_acc;
                    n_state   = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_IDLE;
            r_start   <= 1'b0;
            r_out_vld <= 1'b0;
            r_idx     <= '0;
        end else begin
            r_state   <= n_state;
            r_start   <= n_start;
            r_out_vld <= n_out_vld;
            r_idx     <= n_idx;
        end
    end

    always_ff @(posedge i_clk) begin
        r_term <= n_term;
        r_cur  <= n_cur;
        r_acc  <= n_acc;
        r_opa  <= n_opa;
        r_opb  <= n_opb;
        r_out  <= n_out;
    end

    // bin payload and valid bits; an invalid bin reads as +0.0
    always_ff @(posedge i_clk) begin
        if (w_we) begin
            r_bin[r_idx] <= w_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || w_clr_all) begin
            r_bin_vld <= '0;
        end else if (w_we) begin
            r_bin_vld[r_idx] <= 1'b1;
        end else if (w_clr_one) begin
            r_bin_vld[r_idx] <= 1'b0;
        end
    end

    assign o_m_axis_tvalid = r_out_vld;
    assign o_m_axis_tdata  = r_out;

    // register port, decoded by word index
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;
    assign prdata = (paddr[2] == REG_CAREFUL) ? {31'd0, r_careful} : 32'd0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_careful <= 1'b1;
        end else if (cfg_wr && paddr[2] == REG_CAREFUL) begin
            r_careful <= pwdata[0];
        end
    end

    // the adder is only started when it holds no other operation
    a_add_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_start |-> !add_busy)
        else $error("adder started while busy");

    // a result only arrives while the sequencer waits for one
    a_done_wait: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        add_done |-> (r_state == ST_ACC_WAIT || r_state == ST_SW_WAIT ||
                      r_state == ST_RD_WAIT))
        else $error("adder result with no waiting step");

    // bin index stays within the store
    a_idx_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state != ST_IDLE |-> {1'b0, r_idx} < (IW + 1)'(NUM_BINS))
        else $error("bin index out of range");

    // a pending result beat holds until taken
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(r_out_vld && !i_m_axis_tready) |-> (r_out_vld && $stable(r_out)))
        else $error("pending result lost");

endmodule

FILE: rtl/core/bfa_fp_add.sv
module bfa_fp_add
    import bfa_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_start,
    input  logic [63:0] i_a,
    input  logic [63:0] i_b,
    output logic        o_busy,
    output logic        o_done,
    output logic [63:0] o_res
);

    logic [4:0] r_vld;

    // stage 1: unpack, order by magnitude, specials
    logic        r1_spec, r1_sign, r1_sub;
    logic [63:0] r1_spec_val;
    logic [10:0] r1_ea;
    logic [55:0] r1_ma, r1_mb;
    logic [5:0]  r1_d;

    // stage 2: aligned operands
    logic        r2_spec, r2_sign, r2_sub;
    logic [63:0] r2_spec_val;
    logic [10:0] r2_ea;
    logic [55:0] r2_ma, r2_mb;

    // stage 3: raw sum
    logic        r3_spec, r3_sign, r3_sub;
    logic [63:0] r3_spec_val;
    logic [10:0] r3_ea;
    logic [56:0] r3_sum;

    // stage 4: shift amount
    logic        r4_spec, r4_sign, r4_sub, r4_zero;
    logic [63:0] r4_spec_val;
    logic [10:0] r4_ea;
    logic [56:0] r4_sum;
    logic [5:0]  r4_sh;

    logic [63:0] r_res;

    // stage 1 logic
    logic        a_nan, b_nan, a_inf, b_inf, swap;
    logic [63:0] big, sml;
    logic [10:0] eb_f, es_f, eb, es, ed;
    logic        s1_spec;
    logic [63:0] s1_val;

    always_comb begin
        a_nan = (i_a[62:52] == 11'h7FF) && (i_a[51:0] != 52'd0);
        b_nan = (i_b[62:52] == 11'h7FF) && (i_b[51:0] != 52'd0);
        a_inf = (i_a[62:0] == {11'h7FF, 52'd0});
        b_inf = (i_b[62:0] == {11'h7FF, 52'd0});
        swap  = i_a[62:0] < i_b[62:0];
        big   = swap ? i_b : i_a;
        sml   = swap ? i_a : i_b;
        eb_f  = big[62:52];
        es_f  = sml[62:52];
        eb    = (eb_f == 11'd0) ? 11'd1 : eb_f;
        es    = (es_f == 11'd0) ? 11'd1 : es_f;
        ed    = eb - es;
        s1_spec = 1'b1;
        s1_val  = 64'd0;
        priority if (a_nan) begin
            s1_val = i_a | (64'd1 << 51);
        end else if (b_nan) begin
            s1_val = i_b | (64'd1 << 51);
        end else if (a_inf && b_inf && (i_a[63] != i_b[63])) begin
            s1_val = DEFAULT_NAN;
        end else if (a_inf) begin
            s1_val = i_a;
        end else if (b_inf) begin
            s1_val = i_b;
        end else begin
            s1_spec = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        r1_spec     <= s1_spec;
        r1_spec_val <= s1_val;
        r1_sign     <= big[63];
        r1_sub      <= big[63] ^ sml[63];
        r1_ea       <= eb;
        r1_ma       <= {(eb_f != 11'd0), big[51:0], 3'b000};
        r1_mb       <= {(es_f != 11'd0), sml[51:0], 3'b000};
        r1_d        <= (ed > 11'd63) ? 6'd63 : ed[5:0];
    end

    // stage 2 logic: right shift with sticky
    logic [119:0] ext;
    always_comb begin
        ext = {r1_mb, 64'd0} >> r1_d;
    end

    always_ff @(posedge i_clk) begin
        r2_spec     <= r1_spec;
        r2_spec_val <= r1_spec_val;
        r2_sign     <= r1_sign;
        r2_sub      <= r1_sub;
        r2_ea       <= r1_ea;
        r2_ma       <= r1_ma;
        r2_mb       <= {ext[119:65], ext[64] | (|ext[63:0])};
    end

    always_ff @(posedge i_clk) begin
        r3_spec     <= r2_spec;
        r3_spec_val <= r2_spec_val;
        r3_sign     <= r2_sign;
        r3_sub      <= r2_sub;
        r3_ea       <= r2_ea;
        r3_sum      <= r2_sub ? ({1'b0, r2_ma} - {1'b0, r2_mb})
                              : ({1'b0, r2_ma} + {1'b0, r2_mb});
    end

    // stage 4 logic: leading zero count, limited by exponent
    logic [5:0]  lz;
    logic [10:0] emax;
    logic [5:0]  r4_sh_n;
    always_comb begin
        lz = 6'd56;
        for (int k = 0; k < 56; k++) begin
            if (r3_sum[k]) lz = 6'(55 - k);
        end
        emax = r3_ea - 11'd1;
        r4_sh_n = ({5'd0, lz} > emax) ? emax[5:0] : lz;
    end

    always_ff @(posedge i_clk) begin
        r4_spec     <= r3_spec;
        r4_spec_val <= r3_spec_val;
        r4_sign     <= r3_sign;
        r4_sub      <= r3_sub;
        r4_ea       <= r3_ea;
        r4_sum      <= r3_sum;
        r4_zero     <= (r3_sum == 57'd0);
        r4_sh       <= r4_sh_n;
    end

    // stage 5 logic: normalize and round to nearest even
    logic [55:0] m;
    logic [11:0] e;
    logic [10:0] ef;
    logic        inc;
    logic [62:0] body;
    logic [63:0] s5_res;
    always_comb begin
        if (r4_sum[56]) begin
            m = {r4_sum[56:2], r4_sum[1] | r4_sum[0]};
            e = {1'b0, r4_ea} + 12'd1;
        end else begin
            m = r4_sum[55:0] << r4_sh;
            e = {1'b0, r4_ea} - {6'd0, r4_sh};
        end
        ef   = m[55] ? e[10:0] : 11'd0;
        inc  = m[2] & (m[1] | m[0] | m[3]);
        body = {ef, m[54:3]} + {62'd0, inc};
        if (r4_spec) begin
            s5_res = r4_spec_val;
        end else if (r4_zero) begin
            s5_res = {r4_sign & ~r4_sub, 63'd0};
        end else if (e >= 12'd2047) begin
            s5_res = {r4_sign, 11'h7FF, 52'd0};
        end else begin
            s5_res = {r4_sign, body};
        end
    end

    always_ff @(posedge i_clk) begin
        r_res <= s5_res;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 5'd0;
        end else begin
            r_vld <= {r_vld[3:0], i_start};
        end
    end

    assign o_busy = |r_vld[3:0];
    assign o_done = r_vld[4];
    assign o_res  = r_res;

endmodule

FILE: tb/sv/testbench.sv
module testbench
    import bfa_pkg::*;
;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int NB = 21;

    logic        i_clk;
    logic        i_rst_n;
    logic        s_tvalid;
    logic        s_tready;
    logic [63:0] s_tdata;   // [63:0] term_bits
    logic [1:0]  s_tuser;   // [1:0] opcode
    logic        m_tvalid;
    logic        m_tready;
    logic [63:0] m_tdata;   // [63:0] sum_bits
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [2:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    binned_float_accumulator_unit #(.NUM_BINS(NB)) i_dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (s_tvalid),
        .o_s_axis_tready (s_tready),
        .i_s_axis_tdata  (s_tdata),
        .i_s_axis_tuser  (s_tuser),
        .o_m_axis_tvalid (m_tvalid),
        .i_m_axis_tready (m_tready),
        .o_m_axis_tdata  (m_tdata),
        .psel            (psel),
        .penable         (penable),
        .pwrite          (pwrite),
        .paddr           (paddr),
        .pwdata          (pwdata),
        .prdata          (prdata),
        .pready          (pready)
    );

    // shadow copy of the bins and mode
    real         bin_val [NB];
    logic        careful;
    logic [63:0] sum_queue [$];
    int          err_count;
    bit          calm;      // no idling in the last part
    bit          rx_free;   // receiver never stalls

    typedef struct {
        logic [1:0]  op;
        logic [63:0] term;
        bit          has_sum;
        logic [63:0] sum;
    } t_dir_row;

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    initial begin
        #50ms;
        $display("FAILURE");
        $finish;
    end

    task automatic report(input string what, input logic [63:0] got, input logic [63:0] want);
        $display("mismatch %s: got %h want %h at %0t", what, got, want, $realtime);
        err_count++;
    endtask

    function automatic int bins_used();
        return careful ? NB : 2;
    endfunction

    // predicted sum of the bins in use, finest first
    function automatic logic [63:0] bin_total();
        real acc;
        acc = 0.0;
        for (int k = bins_used() - 1; k >= 0; k--) acc = acc + bin_val[k];
        return $realtobits(acc);
    endfunction

    // apply one accepted beat to the shadow state
    task automatic predict_beat(input logic [1:0] op, input logic [63:0] term);
        real t;
        int  n;
        n = bins_used();
        t = $bitstoreal(term);
        case (op)
            OP_ACC: begin
                for (int k = n - 1; k >= 0; k--) begin
                    if (t < $bitstoreal(CUTOFF[k])) begin
                        bin_val[k] = bin_val[k] + t;
                        break;
                    end
                end
                // carry sweep, finest to coarsest
                for (int k = n - 1; k > 0; k--) begin
                    if (bin_val[k] > $bitstoreal(CUTOFF[k])) begin
                        bin_val[k - 1] = bin_val[k - 1] + bin_val[k];
                        bin_val[k] = 0.0;
                    end
                end
            end
            OP_READ: sum_queue.push_back(bin_total());
            OP_CLEAR: for (int k = 0; k < NB; k++) bin_val[k] = 0.0;
            default: ;
        endcase
    endtask

    // receiver: random stalls, compare each sum beat
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            m_tready <= 1'b0;
        end else begin
            if (m_tvalid && m_tready) begin
                if (sum_queue.size() == 0) begin
                    report("unexpected sum", m_tdata, 64'd0);
                end else begin
                    if (m_tdata !== sum_queue[0]) report("sum_bits", m_tdata, sum_queue[0]);
                    void'(sum_queue.pop_front());
                end
            end
            m_tready <= (calm || rx_free) ? 1'b1 : ($urandom_range(0, 3) != 0);
        end
    end

    task automatic apb_write(input logic [31:0] val);
        psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1; paddr <= 3'd0; pwdata <= val;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
        careful = val[0];
    endtask

    // send one beat, random gap bursts before it
    task automatic send_beat(input logic [1:0] op, input logic [63:0] term);
        if (!calm && $urandom_range(0, 4) == 0) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 5)) @(posedge i_clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= op;
        s_tdata  <= term;
        @(posedge i_clk);
        while (!s_tready) @(posedge i_clk);
        predict_beat(op, term);
    endtask

    // wait out every pending sum and the longest silent item
    task automatic drain();
        s_tvalid <= 1'b0;
        while (sum_queue.size() != 0) @(posedge i_clk);
        repeat (200) @(posedge i_clk);
    endtask

    function automatic logic [63:0] rand_term();
        logic [63:0] b;
        case ($urandom_range(0, 7))
            0: b = {$urandom, $urandom};
            1: b = $realtobits(($urandom_range(0, 1000000) / 1.0e6) * 2.0);
            2: b = $realtobits(-($urandom_range(0, 1000000) / 1.0e6));
            3: b = {1'b0, 11'($urandom_range(0, 1023)), $urandom, 20'($urandom)};
            4: b = {1'($urandom), 11'($urandom_range(0, 1023)), $urandom, 20'($urandom)};
            5: b = {1'b0, 11'($urandom_range(0, 60)), $urandom, 20'($urandom)};
            6: b = $realtobits($urandom_range(1, 3000) * 1.0e-19);
            default: b = $realtobits($urandom_range(1, 1000) * 1.0e-305);
        endcase
        return b;
    endfunction

    // directed table: sums typed in where obvious; each pass opens with a clear of the bins
    t_dir_row dir_rows [23] = '{
        '{OP_CLEAR, 64'h0, 1'b0, 64'h0},
        '{OP_READ,  64'h0, 1'b1, 64'h0},
        '{OP_ACC,   $realtobits(1.5), 1'b0, 64'h0},
        '{OP_READ,  64'h0, 1'b1, $realtobits(1.5)},
        '{OP_ACC,   $realtobits(2.0), 1'b0, 64'h0},
        '{OP_ACC,   64'h7FF0_0000_0000_0000, 1'b0, 64'h0},
        '{OP_ACC,   DEFAULT_NAN, 1'b0, 64'h0},
        '{OP_ACC,   64'h7FF8_0000_0000_0001, 1'b0, 64'h0},
        '{OP_READ,  64'h0, 1'b1, $realtobits(1.5)},
        '{OP_SPARE, 64'hFFFF_FFFF_FFFF_FFFF, 1'b0, 64'h0},
        '{OP_CLEAR, 64'h0, 1'b0, 64'h0},
        '{OP_READ,  64'h0, 1'b1, 64'h0},
        '{OP_ACC,   64'h0000_0000_0000_0001, 1'b0, 64'h0},
        '{OP_ACC,   64'h000F_FFFF_FFFF_FFFF, 1'b0, 64'h0},
        '{OP_ACC,   $realtobits(2.9e-16), 1'b0, 64'h0},
        '{OP_ACC,   $realtobits(1.0e-20), 1'b0, 64'h0},
        '{OP_ACC,   $realtobits(-0.25), 1'b0, 64'h0},
        '{OP_ACC,   64'hFFF0_0000_0000_0000, 1'b0, 64'h0},
        '{OP_READ,  64'h0, 1'b0, 64'h0},
        '{OP_CLEAR, 64'h0, 1'b0, 64'h0},
        '{OP_ACC,   64'h8000_0000_0000_0000, 1'b0, 64'h0},
        '{OP_ACC,   $realtobits(1.9999999), 1'b0, 64'h0},
        '{OP_READ,  64'h0, 1'b0, 64'h0}
    };

    initial begin
        logic [1:0] op;
        int         r;
        i_rst_n = 1'b0;
        s_tvalid = 1'b0; s_tdata = '0; s_tuser = '0;
        psel = 1'b0; penable = 1'b0; pwrite = 1'b0; paddr = '0; pwdata = '0;
        calm = 1'b0; rx_free = 1'b0; err_count = 0; careful = 1'b1;
        for (int k = 0; k < NB; k++) bin_val[k] = 0.0;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed rows, in careful mode then coarse mode
        for (int pass = 0; pass < 2; pass++) begin
            foreach (dir_rows[i]) begin
                send_beat(dir_rows[i].op, dir_rows[i].term);
                if (dir_rows[i].has_sum && dir_rows[i].op == OP_READ &&
                    sum_queue[$] !== dir_rows[i].sum)
                    report("directed prediction", sum_queue[$], dir_rows[i].sum);
            end
            drain();
            apb_write(32'hFFFF_FFFE);   // bit 0 clear: coarse mode
        end

        // random phases across mode settings; bins above 1 persist over mode flips
        for (int ph = 0; ph < 6; ph++) begin
            drain();
            apb_write({31'($urandom), (ph % 2 == 0)});
            if (ph == 5) calm = 1'b1;
            rx_free = (ph == 2);
            for (int n = 0; n < 100; n++) begin
                r = $urandom_range(0, 99);
                op = (r < 70) ? OP_ACC : (r < 94) ? OP_READ : (r < 97) ? OP_CLEAR : OP_SPARE;
                send_beat(op, rand_term());
                if (ph == 3 && n == 50) drain();  // hold off until all sums are back
            end
        end
        drain();

        if (err_count == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule

FILE: files.f
rtl/core/bfa_pkg.sv
rtl/core/bfa_fp_add.sv
rtl/core/binned_float_accumulator_unit.sv
tb/sv/testbench.sv
